@@ sv/ppa_pkg.sv @@
// ----------------------------------------------------------------------------
// ppa_pkg: shared types and constants of the polygon perimeter/area core
// Field widths, datapath widths, and the sequencer state type.
// ----------------------------------------------------------------------------
package ppa_pkg;

    // Beat field widths
    localparam int unsigned CoordW  = 16;
    localparam int unsigned PerimW  = 40;
    localparam int unsigned AreaW   = 43;

    // Datapath widths
    localparam int unsigned DiffW   = CoordW + 1;       // edge delta
    localparam int unsigned ProdW   = 2 * DiffW;        // one product
    localparam int unsigned D2W     = ProdW;            // dx*dx + dy*dy
    localparam int unsigned FracW   = 8;                // perimeter fraction bits
    localparam int unsigned RadW    = D2W + 2 * FracW;  // radicand, 2 bits a digit
    localparam int unsigned RootW   = RadW / 2;         // root bits, one per step
    localparam int unsigned RemW    = RootW + 2;        // partial remainder
    localparam int unsigned SqStepW = $clog2(RootW);
    localparam int unsigned MulStepW = 3;

    // Multiplier pass numbers
    localparam logic [MulStepW-1:0] MulDxDx = 3'd0;
    localparam logic [MulStepW-1:0] MulDyDy = 3'd1;
    localparam logic [MulStepW-1:0] MulAxBy = 3'd2;
    localparam logic [MulStepW-1:0] MulBxAy = 3'd3;
    localparam logic [MulStepW-1:0] MulLast = 3'd4;

    // Vertices seen, saturating
    localparam logic [1:0] MinVertices = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_ACC,
        ST_FIN
    } t_state;

endpackage

@@ sv/ppa_in_if.sv @@
// ----------------------------------------------------------------------------
// ppa_in_if: vertex channel
// One beat carries one polygon vertex and its last-vertex marker.
// ----------------------------------------------------------------------------
interface ppa_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ppa_pkg::CoordW-1:0]   vx;
    logic signed [ppa_pkg::CoordW-1:0]   vy;
    logic                                last_vertex;

    modport source (output valid, output vx, output vy, output last_vertex, input ready);
    modport sink   (input valid, input vx, input vy, input last_vertex, output ready);
endinterface

@@ sv/ppa_out_if.sv @@
// ----------------------------------------------------------------------------
// ppa_out_if: result channel
// One beat carries the perimeter, twice the signed area and the short flag.
// ----------------------------------------------------------------------------
interface ppa_out_if;
    logic                                valid;
    logic                                ready;
    logic        [ppa_pkg::PerimW-1:0]   perimeter;
    logic signed [ppa_pkg::AreaW-1:0]    double_area;
    logic                                too_few;

    modport source (output valid, output perimeter, output double_area, output too_few,
                    input ready);
    modport sink   (input valid, input perimeter, input double_area, input too_few,
                    output ready);
endinterface

@@ sv/polygon_perimeter_and_area_core.sv @@
// ----------------------------------------------------------------------------
// polygon_perimeter_and_area_core: polygon perimeter and shoelace area
// Accumulates edge lengths and cross products over a vertex stream and
// emits one result beat on the vertex marked last.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  i_vtx    | in  | valid/ready   | vx[15:0] s, vy[15:0] s, last_vertex
//  o_res    | out | valid/ready   | perimeter[39:0], double_area[42:0] s, too_few
//
//  Each edge runs passes on one shared 17x17 multiplier (dx*dx, dy*dy,
//  ax*by, bx*ay), then a one-bit-per-cycle square root, then an add.
//  A first vertex that is not last is only stored; any other vertex runs an
//  edge, a last one after others runs the closing edge too, and every last
//  vertex ends with the result load.
//  Synchronous active-low reset clears the perimeter and area sums and the vertex count.
//  i_vtx.ready is high only in idle; the last vertex holds until the output
//  register is free, and a result waits there while the next vertices are taken.
// ----------------------------------------------------------------------------
module polygon_perimeter_and_area_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppa_in_if.sink     i_vtx,
    ppa_out_if.source  o_res
);

    // Sequencer and vertex bookkeeping
    ppa_pkg::t_state                   r_state, n_state;
    logic [1:0]                        r_count, n_count;
    logic                              r_last, n_last;
    logic                              r_edge, n_edge;     // 0: prev->cur, 1: closing
    logic [ppa_pkg::MulStepW-1:0]      r_mstep, n_mstep;
    logic [ppa_pkg::SqStepW-1:0]       r_sstep, n_sstep;

    logic signed [ppa_pkg::CoordW-1:0] r_first_x, n_first_x, r_first_y, n_first_y;
    logic signed [ppa_pkg::CoordW-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic signed [ppa_pkg::CoordW-1:0] r_ax, n_ax, r_ay, n_ay, r_bx, n_bx, r_by, n_by;

    // Arithmetic
    logic signed [ppa_pkg::ProdW-1:0]  r_prod, n_prod;
    logic        [ppa_pkg::D2W-1:0]    r_d2, n_d2;
    logic signed [ppa_pkg::ProdW-1:0]  r_cross, n_cross;
    logic        [ppa_pkg::RadW-1:0]   r_rad, n_rad;
    logic        [ppa_pkg::RemW-1:0]   r_rem, n_rem;
    logic        [ppa_pkg::RootW-1:0]  r_root, n_root;
    logic        [ppa_pkg::PerimW-1:0] r_perim, n_perim;
    logic signed [ppa_pkg::AreaW-1:0]  r_area, n_area;

    // Output register
    logic                              r_out_valid, n_out_valid;
    logic        [ppa_pkg::PerimW-1:0] r_o_perim, n_o_perim;
    logic signed [ppa_pkg::AreaW-1:0]  r_o_area, n_o_area;
    logic                              r_o_few, n_o_few;

    // Combinational helpers
    logic                              accept;
    logic                              out_free;
    logic signed [ppa_pkg::DiffW-1:0]  dx, dy, mul_a, mul_b;
    logic        [ppa_pkg::RemW+1:0]   rem_sh, trial;
    logic        [ppa_pkg::PerimW:0]   perim_sum;
    logic signed [ppa_pkg::AreaW:0]    area_sum;

    assign accept   = i_vtx.valid && (r_state == ppa_pkg::ST_IDLE);
    assign out_free = !r_out_valid || o_res.ready;

    assign i_vtx.ready       = (r_state == ppa_pkg::ST_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.perimeter   = r_o_perim;
    assign o_res.double_area = r_o_area;
    assign o_res.too_few     = r_o_few;

    // Edge deltas and shared multiplier operand select
    assign dx = {r_bx[ppa_pkg::CoordW-1], r_bx} - {r_ax[ppa_pkg::CoordW-1], r_ax};
    assign dy = {r_by[ppa_pkg::CoordW-1], r_by} - {r_ay[ppa_pkg::CoordW-1], r_ay};

    always_comb begin
        case (r_mstep)
            ppa_pkg::MulDxDx: begin
                mul_a = dx;
                mul_b = dx;
            end
            ppa_pkg::MulDyDy: begin
                mul_a = dy;
                mul_b = dy;
            end
            ppa_pkg::MulAxBy: begin
                mul_a = {r_ax[ppa_pkg::CoordW-1], r_ax};
                mul_b = {r_by[ppa_pkg::CoordW-1], r_by};
            end
            ppa_pkg::MulBxAy: begin
                mul_a = {r_bx[ppa_pkg::CoordW-1], r_bx};
                mul_b = {r_ay[ppa_pkg::CoordW-1], r_ay};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Square root digit step: bring down two radicand bits, try 4*root+1
    assign rem_sh = {r_rem, r_rad[ppa_pkg::RadW-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};

    // Sums ahead of saturation
    assign perim_sum = {1'b0, r_perim} + {{(ppa_pkg::PerimW + 1 - ppa_pkg::RootW){1'b0}}, r_root};
    assign area_sum  = {r_area[ppa_pkg::AreaW-1], r_area}
                     + {{(ppa_pkg::AreaW + 1 - ppa_pkg::ProdW){r_cross[ppa_pkg::ProdW-1]}},
                        r_cross};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppa_pkg::ST_IDLE: begin
                if (accept && ((r_count != 2'd0) || i_vtx.last_vertex)) begin
                    n_state = ppa_pkg::ST_MUL;
                end
            end
            ppa_pkg::ST_MUL: begin
                if (r_mstep == ppa_pkg::MulLast) begin
                    n_state = ppa_pkg::ST_SQRT;
                end
            end
            ppa_pkg::ST_SQRT: begin
                if (r_sstep == ppa_pkg::SqStepW'(ppa_pkg::RootW - 1)) begin
                    n_state = ppa_pkg::ST_ACC;
                end
            end
            ppa_pkg::ST_ACC: begin
                if (!r_edge && r_last) begin
                    n_state = ppa_pkg::ST_MUL;
                end else if (r_last) begin
                    n_state = ppa_pkg::ST_FIN;
                end else begin
                    n_state = ppa_pkg::ST_IDLE;
                end
            end
            ppa_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = ppa_pkg::ST_IDLE;
                end
            end
            default: n_state = ppa_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output updates
    always_comb begin
        n_count     = r_count;
        n_last      = r_last;
        n_edge      = r_edge;
        n_mstep     = r_mstep;
        n_sstep     = r_sstep;
        n_first_x   = r_first_x;
        n_first_y   = r_first_y;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_bx        = r_bx;
        n_by        = r_by;
        n_prod      = ppa_pkg::ProdW'(mul_a) * ppa_pkg::ProdW'(mul_b);
        n_d2        = r_d2;
        n_cross     = r_cross;
        n_rad       = r_rad;
        n_rem       = r_rem;
        n_root      = r_root;
        n_perim     = r_perim;
        n_area      = r_area;
        n_out_valid = r_out_valid && !o_res.ready;
        n_o_perim   = r_o_perim;
        n_o_area    = r_o_area;
        n_o_few     = r_o_few;

        case (r_state)
            ppa_pkg::ST_IDLE: begin
                // Take a vertex, set up the edge from the previous one
                if (accept) begin
                    n_last  = i_vtx.last_vertex;
                    n_edge  = (r_count == 2'd0);
                    n_mstep = ppa_pkg::MulDxDx;
                    n_bx    = i_vtx.vx;
                    n_by    = i_vtx.vy;
                    n_prev_x = i_vtx.vx;
                    n_prev_y = i_vtx.vy;
                    if (r_count == 2'd0) begin
                        n_first_x = i_vtx.vx;
                        n_first_y = i_vtx.vy;
                        n_ax      = i_vtx.vx;
                        n_ay      = i_vtx.vy;
                    end else begin
                        n_ax = r_prev_x;
                        n_ay = r_prev_y;
                    end
                    if (r_count != ppa_pkg::MinVertices) begin
                        n_count = r_count + 2'd1;
                    end
                end
            end
            ppa_pkg::ST_MUL: begin
                // Fold the previous pass's product into the sums
                n_mstep = r_mstep + ppa_pkg::MulStepW'(1);
                case (r_mstep)
                    ppa_pkg::MulDyDy: n_d2    = ppa_pkg::D2W'(r_prod);
                    ppa_pkg::MulAxBy: n_d2    = r_d2 + ppa_pkg::D2W'(r_prod);
                    ppa_pkg::MulBxAy: n_cross = r_prod;
                    ppa_pkg::MulLast: begin
                        n_cross = r_cross - r_prod;
                        n_rad   = {r_d2, {(2 * ppa_pkg::FracW){1'b0}}};
                        n_rem   = '0;
                        n_root  = '0;
                        n_sstep = '0;
                    end
                    default: n_d2 = r_d2;
                endcase
            end
            ppa_pkg::ST_SQRT: begin
                // One root bit a cycle
                n_sstep = r_sstep + ppa_pkg::SqStepW'(1);
                n_rad   = {r_rad[ppa_pkg::RadW-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    n_rem  = ppa_pkg::RemW'(rem_sh - trial);
                    n_root = {r_root[ppa_pkg::RootW-2:0], 1'b1};
                end else begin
                    n_rem  = ppa_pkg::RemW'(rem_sh);
                    n_root = {r_root[ppa_pkg::RootW-2:0], 1'b0};
                end
            end
            ppa_pkg::ST_ACC: begin
                // Saturating adds of edge length and cross product
                if (perim_sum[ppa_pkg::PerimW]) begin
                    n_perim = '1;
                end else begin
                    n_perim = perim_sum[ppa_pkg::PerimW-1:0];
                end
                case (area_sum[ppa_pkg::AreaW -: 2])
                    2'b01:   n_area = {1'b0, {(ppa_pkg::AreaW - 1){1'b1}}};
                    2'b10:   n_area = {1'b1, {(ppa_pkg::AreaW - 1){1'b0}}};
                    default: n_area = area_sum[ppa_pkg::AreaW-1:0];
                endcase
                // Set up the closing edge back to the first vertex
                if (!r_edge && r_last) begin
                    n_edge  = 1'b1;
                    n_mstep = ppa_pkg::MulDxDx;
                    n_ax    = r_bx;
                    n_ay    = r_by;
                    n_bx    = r_first_x;
                    n_by    = r_first_y;
                end
            end
            ppa_pkg::ST_FIN: begin
                // Load the result beat and start a new polygon
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_perim   = r_perim;
                    n_o_area    = r_area;
                    n_o_few     = (r_count != ppa_pkg::MinVertices);
                    n_count     = 2'd0;
                    n_perim     = '0;
                    n_area      = '0;
                end
            end
            default: n_count = r_count;
        endcase
    end

    // Control and accumulator registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppa_pkg::ST_IDLE;
            r_count     <= 2'd0;
            r_last      <= 1'b0;
            r_edge      <= 1'b0;
            r_mstep     <= '0;
            r_sstep     <= '0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_perim     <= '0;
            r_area      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_last      <= n_last;
            r_edge      <= n_edge;
            r_mstep     <= n_mstep;
            r_sstep     <= n_sstep;
            r_first_x   <= n_first_x;
            r_first_y   <= n_first_y;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_perim     <= n_perim;
            r_area      <= n_area;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_bx      <= n_bx;
        r_by      <= n_by;
        r_prod    <= n_prod;
        r_d2      <= n_d2;
        r_cross   <= n_cross;
        r_rad     <= n_rad;
        r_rem     <= n_rem;
        r_root    <= n_root;
        r_o_perim <= n_o_perim;
        r_o_area  <= n_o_area;
        r_o_few   <= n_o_few;
    end

endmodule
